FILE: hw/rtl/abbt_pkg.sv
// abbt_pkg: item types, register indexes and pipeline constants for the
// affine bounding box transform. No dependencies.

package abbt_pkg;

    localparam int DATA_W      = 32;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int HALF_W      = 32;
    localparam int NUM_AXES    = 3;
    localparam int NUM_CORNERS = 8;
    localparam int NUM_STAGES  = 6;

    localparam logic [CFG_INDEX_W-1:0] REG_XROW_CX_CY    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_XROW_CZ_SHIFT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_YROW_CX_CY    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_YROW_CZ_SHIFT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ZROW_CX_CY    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ZROW_CZ_SHIFT = 3'd5;

    typedef struct packed {
        logic signed [DATA_W-1:0] box_low_x;
        logic signed [DATA_W-1:0] box_low_y;
        logic signed [DATA_W-1:0] box_low_z;
        logic signed [DATA_W-1:0] box_high_x;
        logic signed [DATA_W-1:0] box_high_y;
        logic signed [DATA_W-1:0] box_high_z;
    } box_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_low_x;
        logic signed [DATA_W-1:0] out_low_y;
        logic signed [DATA_W-1:0] out_low_z;
        logic signed [DATA_W-1:0] out_high_x;
        logic signed [DATA_W-1:0] out_high_y;
        logic signed [DATA_W-1:0] out_high_z;
    } result_item_t;

    // load enables, one per pipeline stage
    typedef struct packed {
        logic prod;
        logic sum;
        logic sat;
        logic lvl1;
        logic lvl2;
        logic lvl3;
    } stage_en_t;

endpackage

FILE: hw/rtl/abbt_products.sv
// abbt_products: registered coefficient-by-coordinate products for both
// corner values of each input axis. Depends on abbt_pkg.

module abbt_products #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                   clk,
    input  abbt_pkg::stage_en_t                    en,
    input  logic [2:0][2:0][COORD_WIDTH-1:0]       coef,
    input  logic [2:0][COORD_WIDTH-1:0]            lo_coord,
    input  logic [2:0][COORD_WIDTH-1:0]            hi_coord,
    output logic [2:0][2:0][2*COORD_WIDTH-1:0]     prod_lo_reg,
    output logic [2:0][2:0][2*COORD_WIDTH-1:0]     prod_hi_reg
);

    localparam int PW = 2 * COORD_WIDTH;

    logic [2:0][2:0][PW-1:0] prod_lo_next;
    logic [2:0][2:0][PW-1:0] prod_hi_next;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_lo_next[r][c] = PW'($signed(coef[r][c]) * $signed(lo_coord[c]));
                prod_hi_next[r][c] = PW'($signed(coef[r][c]) * $signed(hi_coord[c]));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.prod)
        begin
            prod_lo_reg <= prod_lo_next;
            prod_hi_reg <= prod_hi_next;
        end
    end

endmodule

FILE: hw/rtl/abbt_lane.sv
// abbt_lane: one corner lane; sums the three products per output axis,
// floor-shifts, adds the row shift and saturates. Depends on abbt_pkg.

module abbt_lane #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                clk,
    input  abbt_pkg::stage_en_t                 en,
    input  logic [2:0][2:0][2*COORD_WIDTH-1:0]  prod,
    input  logic [2:0][COORD_WIDTH-1:0]         shift,
    output logic [2:0][COORD_WIDTH-1:0]         sat_reg
);

    localparam int SW = 2 * COORD_WIDTH + 2;
    localparam int VW = 2 * COORD_WIDTH + 3;
    localparam logic signed [VW-1:0] SAT_HI =
        VW'($signed({1'b0, {(COORD_WIDTH-1){1'b1}}}));
    localparam logic signed [VW-1:0] SAT_LO =
        VW'($signed({1'b1, {(COORD_WIDTH-1){1'b0}}}));

    logic [2:0][SW-1:0]          sum_next;
    logic [2:0][SW-1:0]          sum_reg;
    logic [2:0][COORD_WIDTH-1:0] sat_next;
    logic signed [VW-1:0]        val [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sum_next[r] = SW'($signed(prod[r][0])) + SW'($signed(prod[r][1]))
                        + SW'($signed(prod[r][2]));
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            val[r] = (VW'($signed(sum_reg[r])) >>> FRAC_BITS) + VW'($signed(shift[r]));
            if (val[r] > SAT_HI)
            begin
                sat_next[r] = SAT_HI[COORD_WIDTH-1:0];
            end
            else if (val[r] < SAT_LO)
            begin
                sat_next[r] = SAT_LO[COORD_WIDTH-1:0];
            end
            else
            begin
                sat_next[r] = val[r][COORD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.sum)
        begin
            sum_reg <= sum_next;
        end
        if (en.sat)
        begin
            sat_reg <= sat_next;
        end
    end

endmodule

FILE: hw/rtl/abbt_merge.sv
// abbt_merge: three-level registered min/max tree over the eight corner
// lanes, per output axis. Depends on abbt_pkg.

module abbt_merge #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                   clk,
    input  abbt_pkg::stage_en_t                    en,
    input  logic [7:0][2:0][COORD_WIDTH-1:0]       lane_val,
    output logic [2:0][COORD_WIDTH-1:0]            min_reg,
    output logic [2:0][COORD_WIDTH-1:0]            max_reg
);

    logic [3:0][2:0][COORD_WIDTH-1:0] l1_min_next, l1_max_next, l1_min_reg, l1_max_reg;
    logic [1:0][2:0][COORD_WIDTH-1:0] l2_min_next, l2_max_next, l2_min_reg, l2_max_reg;
    logic [2:0][COORD_WIDTH-1:0]      min_next, max_next;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                if ($signed(lane_val[2*i][a]) < $signed(lane_val[2*i+1][a]))
                begin
                    l1_min_next[i][a] = lane_val[2*i][a];
                    l1_max_next[i][a] = lane_val[2*i+1][a];
                end
                else
                begin
                    l1_min_next[i][a] = lane_val[2*i+1][a];
                    l1_max_next[i][a] = lane_val[2*i][a];
                end
            end
            for (int i = 0; i < 2; i++)
            begin
                l2_min_next[i][a] = ($signed(l1_min_reg[2*i][a]) < $signed(l1_min_reg[2*i+1][a]))
                                  ? l1_min_reg[2*i][a] : l1_min_reg[2*i+1][a];
                l2_max_next[i][a] = ($signed(l1_max_reg[2*i][a]) > $signed(l1_max_reg[2*i+1][a]))
                                  ? l1_max_reg[2*i][a] : l1_max_reg[2*i+1][a];
            end
            min_next[a] = ($signed(l2_min_reg[0][a]) < $signed(l2_min_reg[1][a]))
                        ? l2_min_reg[0][a] : l2_min_reg[1][a];
            max_next[a] = ($signed(l2_max_reg[0][a]) > $signed(l2_max_reg[1][a]))
                        ? l2_max_reg[0][a] : l2_max_reg[1][a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.lvl1)
        begin
            l1_min_reg <= l1_min_next;
            l1_max_reg <= l1_max_next;
        end
        if (en.lvl2)
        begin
            l2_min_reg <= l2_min_next;
            l2_max_reg <= l2_max_next;
        end
        if (en.lvl3)
        begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

endmodule

FILE: hw/rtl/affine_bounding_box_transform_top.sv
// affine_bounding_box_transform_top: config registers, pipeline control,
// products, eight corner lanes and the min/max merge.
// Depends on abbt_pkg, abbt_products, abbt_lane, abbt_merge.
//
//   channel   signals                              direction
//   box       box_valid, box_ready, box            in
//   result    result_valid, result_ready, result   out
//   config    cfg_we, cfg_index, cfg_data          in
//
// One item per cycle while the result side keeps up; a result passes the stages in
// order after acceptance (products, lane sum, lane saturate, three merge levels).
// Reset: transform is identity, pipeline empty.
// Each stage loads when it is empty or the stage after it moves, so a box is
// still taken while a result waits, as long as some stage holds a bubble.

module affine_bounding_box_transform_top #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  box_valid,
    output logic                                  box_ready,
    input  abbt_pkg::box_item_t                   box,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output abbt_pkg::result_item_t                result,
    input  logic                                  cfg_we,
    input  logic [abbt_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [abbt_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int NS = abbt_pkg::NUM_STAGES;
    localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;
    localparam logic [COORD_WIDTH-1:0] DIAG = ONE[COORD_WIDTH-1:0];

    logic [2:0][2:0][COORD_WIDTH-1:0]     coef_reg;
    logic [2:0][COORD_WIDTH-1:0]          shift_reg;
    logic [NS-1:0]                        valid_reg;
    logic [NS-1:0]                        valid_next;
    logic [NS-1:0]                        rdy;
    abbt_pkg::stage_en_t                  en;
    logic [2:0][COORD_WIDTH-1:0]          lo_coord, hi_coord;
    logic [2:0][2:0][2*COORD_WIDTH-1:0]   prod_lo, prod_hi;
    logic [7:0][2:0][2:0][2*COORD_WIDTH-1:0] lane_prod;
    logic [7:0][2:0][COORD_WIDTH-1:0]     lane_val;
    logic [2:0][COORD_WIDTH-1:0]          min_val, max_val;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    coef_reg[r][c] <= (r == c) ? DIAG : '0;
                end
                shift_reg[r] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                abbt_pkg::REG_XROW_CX_CY:
                begin
                    coef_reg[0][0] <= cfg_data[COORD_WIDTH-1:0];
                    coef_reg[0][1] <= cfg_data[abbt_pkg::HALF_W +: COORD_WIDTH];
                end
                abbt_pkg::REG_XROW_CZ_SHIFT:
                begin
                    coef_reg[0][2] <= cfg_data[COORD_WIDTH-1:0];
                    shift_reg[0]   <= cfg_data[abbt_pkg::HALF_W +: COORD_WIDTH];
                end
                abbt_pkg::REG_YROW_CX_CY:
                begin
                    coef_reg[1][0] <= cfg_data[COORD_WIDTH-1:0];
                    coef_reg[1][1] <= cfg_data[abbt_pkg::HALF_W +: COORD_WIDTH];
                end
                abbt_pkg::REG_YROW_CZ_SHIFT:
                begin
                    coef_reg[1][2] <= cfg_data[COORD_WIDTH-1:0];
                    shift_reg[1]   <= cfg_data[abbt_pkg::HALF_W +: COORD_WIDTH];
                end
                abbt_pkg::REG_ZROW_CX_CY:
                begin
                    coef_reg[2][0] <= cfg_data[COORD_WIDTH-1:0];
                    coef_reg[2][1] <= cfg_data[abbt_pkg::HALF_W +: COORD_WIDTH];
                end
                abbt_pkg::REG_ZROW_CZ_SHIFT:
                begin
                    coef_reg[2][2] <= cfg_data[COORD_WIDTH-1:0];
                    shift_reg[2]   <= cfg_data[abbt_pkg::HALF_W +: COORD_WIDTH];
                end
                default:
                begin
                end
            endcase
        end
    end

    // pipeline control
    always_comb
    begin
        rdy[NS-1] = !valid_reg[NS-1] || result_ready;
        for (int s = NS - 2; s >= 0; s--)
        begin
            rdy[s] = !valid_reg[s] || rdy[s+1];
        end
        valid_next = valid_reg;
        if (rdy[0])
        begin
            valid_next[0] = box_valid;
        end
        for (int s = 1; s < NS; s++)
        begin
            if (rdy[s])
            begin
                valid_next[s] = valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign en.prod      = rdy[0];
    assign en.sum       = rdy[1];
    assign en.sat       = rdy[2];
    assign en.lvl1      = rdy[3];
    assign en.lvl2      = rdy[4];
    assign en.lvl3      = rdy[5];
    assign box_ready    = rdy[0];
    assign result_valid = valid_reg[NS-1];

    // datapath
    assign lo_coord[0] = box.box_low_x[COORD_WIDTH-1:0];
    assign lo_coord[1] = box.box_low_y[COORD_WIDTH-1:0];
    assign lo_coord[2] = box.box_low_z[COORD_WIDTH-1:0];
    assign hi_coord[0] = box.box_high_x[COORD_WIDTH-1:0];
    assign hi_coord[1] = box.box_high_y[COORD_WIDTH-1:0];
    assign hi_coord[2] = box.box_high_z[COORD_WIDTH-1:0];

    abbt_products #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_products (
        .clk         (clk),
        .en          (en),
        .coef        (coef_reg),
        .lo_coord    (lo_coord),
        .hi_coord    (hi_coord),
        .prod_lo_reg (prod_lo),
        .prod_hi_reg (prod_hi)
    );

    // corner k takes the high value of axis c when bit c of k is set
    for (genvar k = 0; k < abbt_pkg::NUM_CORNERS; k++)
    begin : g_lane
        for (genvar r = 0; r < 3; r++)
        begin : g_row
            for (genvar c = 0; c < 3; c++)
            begin : g_term
                if (((k >> c) & 1) == 1)
                begin : g_hi
                    assign lane_prod[k][r][c] = prod_hi[r][c];
                end
                else
                begin : g_lo
                    assign lane_prod[k][r][c] = prod_lo[r][c];
                end
            end
        end

        abbt_lane #(
            .COORD_WIDTH (COORD_WIDTH),
            .FRAC_BITS   (FRAC_BITS)
        ) u_lane (
            .clk     (clk),
            .en      (en),
            .prod    (lane_prod[k]),
            .shift   (shift_reg),
            .sat_reg (lane_val[k])
        );
    end

    abbt_merge #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_merge (
        .clk      (clk),
        .en       (en),
        .lane_val (lane_val),
        .min_reg  (min_val),
        .max_reg  (max_val)
    );

    assign result.out_low_x  = abbt_pkg::DATA_W'($signed(min_val[0]));
    assign result.out_low_y  = abbt_pkg::DATA_W'($signed(min_val[1]));
    assign result.out_low_z  = abbt_pkg::DATA_W'($signed(min_val[2]));
    assign result.out_high_x = abbt_pkg::DATA_W'($signed(max_val[0]));
    assign result.out_high_y = abbt_pkg::DATA_W'($signed(max_val[1]));
    assign result.out_high_z = abbt_pkg::DATA_W'($signed(max_val[2]));

`ifndef NO_ASSERTIONS
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ($signed(min_val[0]) <= $signed(max_val[0]))
                      && ($signed(min_val[1]) <= $signed(max_val[1]))
                      && ($signed(min_val[2]) <= $signed(max_val[2])))
        else $error("merged minimum above maximum");

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        ((&valid_reg) && !result_ready) |-> !box_ready)
        else $error("box taken while every stage is full and stalled");

    a_accept_fills_first: assert property (@(posedge clk) disable iff (!rst_n)
        (box_valid && box_ready) |=> valid_reg[0])
        else $error("accepted box did not enter the product stage");
`endif

endmodule

FILE: sim/affine_bounding_box_transform_top_tb.sv
// Testbench for affine_bounding_box_transform_top: directed and random boxes under
// several transforms, checked against an in-bench bounds predictor.
// Depends on abbt_pkg and the affine_bounding_box_transform_top RTL.

module affine_bounding_box_transform_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W     = 32;
    localparam int FRAC        = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_BOXES = 155;

    localparam logic [abbt_pkg::CFG_INDEX_W-1:0] REG_UNUSED_6 = 3'd6;
    localparam logic [abbt_pkg::CFG_INDEX_W-1:0] REG_UNUSED_7 = 3'd7;

    localparam logic signed [31:0] MIN_C  = 32'sh8000_0000;
    localparam logic signed [31:0] MAX_C  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] ONE_C  = 32'sh0001_0000;
    localparam logic signed [31:0] HALF_C = 32'sh0000_8000;

    logic                             clk          = 1'b0;
    logic                             rst_n        = 1'b0;
    logic                             box_valid    = 1'b0;
    logic                             box_ready;
    abbt_pkg::box_item_t              box          = '0;
    logic                             result_valid;
    logic                             result_ready = 1'b0;
    abbt_pkg::result_item_t           result;
    logic                             cfg_we       = 1'b0;
    logic [abbt_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [abbt_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;

    logic [abbt_pkg::CFG_DATA_W-1:0]  xform [abbt_pkg::NUM_AXES*2];
    abbt_pkg::result_item_t           expected_bounds [$];
    int                               error_count = 0;
    int                               cycle_count = 0;
    bit                               box_quiet   = 1'b0;
    bit                               res_quiet   = 1'b0;

    string field_names [6] = '{"out_low_x", "out_low_y", "out_low_z",
                               "out_high_x", "out_high_y", "out_high_z"};

    affine_bounding_box_transform_top #(
        .COORD_WIDTH(COORD_W),
        .FRAC_BITS  (FRAC)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .box_valid   (box_valid),
        .box_ready   (box_ready),
        .box         (box),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_error(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic int draw_wait(inout bit quiet);
        if ($urandom_range(0, 39) == 0)
            quiet = !quiet;
        return quiet ? 0 : $urandom_range(0, 19);
    endfunction

    // one output axis of one corner: exact sum, floor shift, add shift, saturate
    function automatic logic signed [31:0] map_axis(logic [63:0] r_xy, logic [63:0] r_zs,
                                                    logic signed [31:0] x,
                                                    logic signed [31:0] y,
                                                    logic signed [31:0] z);
        logic signed [31:0] cx, cy, cz, sh;
        logic signed [67:0] p0, p1, p2, acc;
        cx  = r_xy[31:0];
        cy  = r_xy[63:32];
        cz  = r_zs[31:0];
        sh  = r_zs[63:32];
        p0  = cx * x;
        p1  = cy * y;
        p2  = cz * z;
        acc = ((p0 + p1 + p2) >>> FRAC) + sh;
        if (acc > 68'sd2147483647)
            return MAX_C;
        if (acc < -68'sd2147483648)
            return MIN_C;
        return acc[31:0];
    endfunction

    function automatic abbt_pkg::result_item_t predict_bounds(abbt_pkg::box_item_t b);
        logic signed [31:0]     lo [3];
        logic signed [31:0]     hi [3];
        logic signed [31:0]     c [3];
        logic signed [31:0]     mn [3];
        logic signed [31:0]     mx [3];
        logic signed [31:0]     v;
        abbt_pkg::result_item_t r;
        lo = '{b.box_low_x, b.box_low_y, b.box_low_z};
        hi = '{b.box_high_x, b.box_high_y, b.box_high_z};
        for (int k = 0; k < abbt_pkg::NUM_CORNERS; k++)
        begin
            for (int a = 0; a < abbt_pkg::NUM_AXES; a++)
                c[a] = k[a] ? hi[a] : lo[a];
            for (int a = 0; a < abbt_pkg::NUM_AXES; a++)
            begin
                v = map_axis(xform[abbt_pkg::REG_XROW_CX_CY + 2*a],
                             xform[abbt_pkg::REG_XROW_CZ_SHIFT + 2*a],
                             c[0], c[1], c[2]);
                if (k == 0 || v < mn[a])
                    mn[a] = v;
                if (k == 0 || v > mx[a])
                    mx[a] = v;
            end
        end
        r = '{mn[0], mn[1], mn[2], mx[0], mx[1], mx[2]};
        return r;
    endfunction

    function automatic abbt_pkg::box_item_t mk_box(logic signed [31:0] lx,
                                                   logic signed [31:0] ly,
                                                   logic signed [31:0] lz,
                                                   logic signed [31:0] hx,
                                                   logic signed [31:0] hy,
                                                   logic signed [31:0] hz);
        abbt_pkg::box_item_t b;
        b = '{lx, ly, lz, hx, hy, hz};
        return b;
    endfunction

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0:       return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            1:       return $urandom();
            default:
                case ($urandom_range(0, 5))
                    0:       return MIN_C;
                    1:       return MAX_C;
                    2:       return 32'h0;
                    3:       return 32'hFFFF_FFFF;
                    4:       return ONE_C;
                    default: return -ONE_C;
                endcase
        endcase
    endfunction

    function automatic logic [31:0] rand_half();
        case ($urandom_range(0, 7))
            0, 1, 2, 3: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            4, 5:       return $urandom();
            6:          return rand_coord(2);
            default:    return 32'h0;
        endcase
    endfunction

    task automatic write_reg(logic [abbt_pkg::CFG_INDEX_W-1:0] idx,
                             logic [abbt_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx <= abbt_pkg::REG_ZROW_CZ_SHIFT)
            xform[idx] = val;
        @(posedge clk);
    endtask

    task automatic send_box(abbt_pkg::box_item_t b);
        int pause;
        pause = draw_wait(box_quiet);
        if (pause > 0)
        begin
            box_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        box_valid <= 1'b1;
        box       <= b;
        @(posedge clk);
        while (!box_ready)
            @(posedge clk);
        expected_bounds.push_back(predict_bounds(b));
    endtask

    task automatic wait_drained();
        box_valid <= 1'b0;
        while (expected_bounds.size() != 0)
            @(posedge clk);
    endtask

    // receiver: per item stall, then hold ready until the item is taken
    initial
    begin
        int stall;
        @(posedge clk iff rst_n);
        forever
        begin
            stall = draw_wait(res_quiet);
            if (stall > 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        abbt_pkg::result_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_bounds.size() == 0)
                report_error("result with no box outstanding");
            else
            begin
                want = expected_bounds.pop_front();
                for (int i = 0; i < 6; i++)
                    if (result[191-32*i -: 32] !== want[191-32*i -: 32])
                        report_error($sformatf("%s got %0d want %0d", field_names[i],
                                               $signed(result[191-32*i -: 32]),
                                               $signed(want[191-32*i -: 32])));
            end
        end
    end

    // reset transform is identity
    task automatic test_identity_box();
        send_box(mk_box(0, 0, 0, 0, 0, 0));
        send_box(mk_box(MIN_C, MIN_C, MIN_C, MAX_C, MAX_C, MAX_C));
        send_box(mk_box(MAX_C, MAX_C, MAX_C, MIN_C, MIN_C, MIN_C));
        send_box(mk_box(-(ONE_C + HALF_C), 2*ONE_C, -3*ONE_C - 16384,
                        4*ONE_C, -5*ONE_C, 6*ONE_C));
        send_box(mk_box(-1, -1, -1, 1, 1, 1));
    endtask

    // fractional coefficients, negative products must floor
    task automatic test_fractional_floor();
        wait_drained();
        write_reg(abbt_pkg::REG_XROW_CX_CY,    {-HALF_C, HALF_C});
        write_reg(abbt_pkg::REG_XROW_CZ_SHIFT, {-3*ONE_C, 32'sh0000_4000});
        write_reg(abbt_pkg::REG_YROW_CX_CY,    {32'sh0000_C000, -ONE_C});
        write_reg(abbt_pkg::REG_YROW_CZ_SHIFT, {ONE_C, 32'sh0});
        write_reg(abbt_pkg::REG_ZROW_CX_CY,    {32'shFFFF_FFFF, 32'sh0000_0001});
        write_reg(abbt_pkg::REG_ZROW_CZ_SHIFT, {32'sh0, ONE_C});
        send_box(mk_box(-1, -1, -1, 1, 3, -7));
        send_box(mk_box(-3, 5, 7, 32'sh7FFF, -32'sh8001, 3));
        send_box(mk_box(rand_coord(0), rand_coord(0), rand_coord(0),
                        rand_coord(0), rand_coord(0), rand_coord(0)));
        send_box(mk_box(rand_coord(1), rand_coord(1), rand_coord(1),
                        rand_coord(1), rand_coord(1), rand_coord(1)));
    endtask

    // extreme coefficients and shifts drive every axis into saturation on the limit boxes
    task automatic test_saturation();
        wait_drained();
        write_reg(abbt_pkg::REG_XROW_CX_CY,    {MAX_C, MAX_C});
        write_reg(abbt_pkg::REG_XROW_CZ_SHIFT, {MAX_C, MAX_C});
        write_reg(abbt_pkg::REG_YROW_CX_CY,    {MIN_C, MIN_C});
        write_reg(abbt_pkg::REG_YROW_CZ_SHIFT, {MIN_C, MIN_C});
        write_reg(abbt_pkg::REG_ZROW_CX_CY,    {MIN_C, MAX_C});
        write_reg(abbt_pkg::REG_ZROW_CZ_SHIFT, {32'sh0, MAX_C});
        send_box(mk_box(MIN_C, MIN_C, MIN_C, MAX_C, MAX_C, MAX_C));
        send_box(mk_box(MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C));
        send_box(mk_box(MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C));
        send_box(mk_box(0, 0, 0, 0, 0, 0));
        send_box(mk_box(-1, -1, -1, 1, 1, 1));
    endtask

    // writes to indexes past the last register are dropped
    task automatic test_unknown_index();
        wait_drained();
        write_reg(REG_UNUSED_6, '1);
        write_reg(REG_UNUSED_7, {$urandom(), $urandom()});
        send_box(mk_box(MIN_C, 0, MAX_C, ONE_C, -ONE_C, 0));
        send_box(mk_box(ONE_C, 2*ONE_C, 3*ONE_C, -ONE_C, -2*ONE_C, -3*ONE_C));
        send_box(mk_box(-1, -1, -1, -1, -1, -1));
    endtask

    task automatic test_random_transforms();
        int mode;
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            wait_drained();
            for (int r = 0; r <= abbt_pkg::REG_ZROW_CZ_SHIFT; r++)
                write_reg(abbt_pkg::CFG_INDEX_W'(r), {rand_half(), rand_half()});
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? REG_UNUSED_6 : REG_UNUSED_7,
                          {$urandom(), $urandom()});
            for (int n = 0; n < PHASE_BOXES; n++)
            begin
                mode = $urandom_range(0, 9);
                if (mode < 5)
                    send_box(mk_box(rand_coord(0), rand_coord(0), rand_coord(0),
                                    rand_coord(0), rand_coord(0), rand_coord(0)));
                else if (mode < 8)
                    send_box(mk_box(rand_coord(1), rand_coord(1), rand_coord(1),
                                    rand_coord(1), rand_coord(1), rand_coord(1)));
                else
                    send_box(mk_box(rand_coord($urandom_range(0, 2)),
                                    rand_coord($urandom_range(0, 2)),
                                    rand_coord($urandom_range(0, 2)),
                                    rand_coord($urandom_range(0, 2)),
                                    rand_coord($urandom_range(0, 2)),
                                    rand_coord($urandom_range(0, 2))));
            end
        end
    endtask

    initial
    begin
        xform[abbt_pkg::REG_XROW_CX_CY]    = 64'(ONE_C);
        xform[abbt_pkg::REG_XROW_CZ_SHIFT] = '0;
        xform[abbt_pkg::REG_YROW_CX_CY]    = 64'(ONE_C) << abbt_pkg::HALF_W;
        xform[abbt_pkg::REG_YROW_CZ_SHIFT] = '0;
        xform[abbt_pkg::REG_ZROW_CX_CY]    = '0;
        xform[abbt_pkg::REG_ZROW_CZ_SHIFT] = 64'(ONE_C);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_identity_box();
        test_fractional_floor();
        test_saturation();
        test_unknown_index();
        test_random_transforms();

        wait_drained();
        repeat (abbt_pkg::NUM_STAGES * 4) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
